// ----- rtl/core/lcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card checksum classifier package
// Shared widths, step counts, the verdict code and the result record.
// ----------------------------------------------------------------------------
package lcc_pkg;

    // Card number and its decimal form
    localparam int CARD_W        = 64;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 20;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;

    // Binary to decimal conversion: four bits per cycle
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
    localparam int CONV_CNT_W    = $clog2(CONV_STEPS);

    // Digit scan: two digits per cycle
    localparam int NUM_PAIRS     = NUM_DIGITS / 2;
    localparam int PAIR_CNT_W    = $clog2(NUM_PAIRS);
    localparam int LEN_W         = $clog2(NUM_DIGITS + 1);

    // Result fields
    localparam int SUM_W         = 8;
    localparam int SUM_MAX       = 171;
    localparam int M_TDATA_W     = 16;

    localparam int MAX_DIGITS_DEFAULT = 19;

    typedef enum logic [1:0] {
        VERDICT_INVALID    = 2'd0,
        VERDICT_AMEX       = 2'd1,
        VERDICT_MASTERCARD = 2'd2,
        VERDICT_VISA       = 2'd3
    } lcc_verdict_t;

    typedef struct packed {
        lcc_verdict_t       verdict;
        logic               luhn_ok;
        logic [SUM_W-1:0]   digit_sum;
    } lcc_result_t;

endpackage

// ----- rtl/core/lcc_bcd_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-three conversion of the card number, four bits per cycle,
// most significant bit first. Pulses done when all digits are settled.
// ----------------------------------------------------------------------------
module lcc_bcd_conv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lcc_pkg::CARD_W-1:0]  card_value,
    output logic                        done,
    output logic [lcc_pkg::BCD_W-1:0]   bcd
);
    import lcc_pkg::*;

    typedef enum logic {CV_IDLE, CV_RUN} cv_state_t;

    cv_state_t               state_reg;
    logic [CARD_W-1:0]       bin_reg;
    logic [BCD_W-1:0]        bcd_reg;
    logic [BCD_W-1:0]        bcd_next;
    logic [CONV_CNT_W-1:0]   cnt_reg;
    logic                    done_reg;

    // Four adjust-and-shift steps on all digits
    always_comb begin
        logic [BCD_W-1:0] acc;
        acc = bcd_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (acc[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bin_reg[CARD_W-1-s]};
        end
        bcd_next = acc;
    end

    // Load, step and finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                CV_IDLE: begin
                    if (start) begin
                        bin_reg   <= card_value;
                        bcd_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= CV_RUN;
                    end
                end
                CV_RUN: begin
                    bin_reg <= bin_reg << BITS_PER_STEP;
                    bcd_reg <= bcd_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CONV_CNT_W'(CONV_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= CV_IDLE;
                    end
                end
                default: state_reg <= CV_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- rtl/core/lcc_luhn_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luhn digit scan and brand classifier
// Walks the decimal digits two per cycle from the least significant end,
// builds the weighted sum, its remainder mod ten, the digit count and the
// two leading digits, then classifies the card in a final state.
// ----------------------------------------------------------------------------
module lcc_luhn_scan #(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lcc_pkg::BCD_W-1:0]   bcd,
    output logic                        done,
    output lcc_pkg::lcc_result_t        result
);
    import lcc_pkg::*;

    typedef enum logic [1:0] {SC_IDLE, SC_RUN, SC_CLASS} sc_state_t;

    localparam logic [LEN_W-1:0] MAX_D = LEN_W'(MAX_DIGITS);

    sc_state_t               state_reg;
    logic [BCD_W-1:0]        sh_reg;
    logic [PAIR_CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [DIGIT_W-1:0]      mod_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [DIGIT_W-1:0]      top_reg;
    logic [DIGIT_W-1:0]      sec_reg;
    logic [DIGIT_W-1:0]      prev_hi_reg;
    logic                    done_reg;
    lcc_result_t             result_reg;

    logic [DIGIT_W-1:0]      lo_dig;
    logic [DIGIT_W-1:0]      hi_dig;
    logic [DIGIT_W-1:0]      lo_c;
    logic [DIGIT_W-1:0]      hi_c;
    logic [DIGIT_W:0]        hi_dbl;
    logic [LEN_W-1:0]        pos_lo;
    logic [LEN_W-1:0]        pos_hi;
    logic [DIGIT_W:0]        mod_sum;
    logic [DIGIT_W-1:0]      mod_next;
    lcc_result_t             class_next;

    // Digit pair at the bottom of the shift register
    assign lo_dig = sh_reg[DIGIT_W-1:0];
    assign hi_dig = sh_reg[2*DIGIT_W-1:DIGIT_W];
    assign pos_lo = {cnt_reg, 1'b0};
    assign pos_hi = pos_lo + 1'b1;

    // Weighted contributions; digits beyond the limit count as zero
    always_comb begin
        hi_dbl = {hi_dig, 1'b0};
        lo_c   = (pos_lo < MAX_D) ? lo_dig : '0;
        if (pos_hi >= MAX_D) begin
            hi_c = '0;
        end else if (hi_dig >= 4'd5) begin
            hi_c = DIGIT_W'(hi_dbl - 5'd9);
        end else begin
            hi_c = DIGIT_W'(hi_dbl);
        end
    end

    // Running remainder mod ten: sum stays below thirty, fold at most twice
    always_comb begin
        mod_sum = (DIGIT_W+1)'(mod_reg) + (DIGIT_W+1)'(lo_c) + (DIGIT_W+1)'(hi_c);
        priority if (mod_sum >= 5'd20) begin
            mod_next = DIGIT_W'(mod_sum - 5'd20);
        end else if (mod_sum >= 5'd10) begin
            mod_next = DIGIT_W'(mod_sum - 5'd10);
        end else begin
            mod_next = DIGIT_W'(mod_sum);
        end
    end

    // Brand from digit count and leading digits, gated by the checksum
    always_comb begin
        class_next.digit_sum = sum_reg;
        class_next.luhn_ok   = (mod_reg == '0);
        class_next.verdict   = VERDICT_INVALID;
        if (class_next.luhn_ok) begin
            priority if (len_reg == LEN_W'(15) && top_reg == 4'd3 &&
                         (sec_reg == 4'd4 || sec_reg == 4'd7)) begin
                class_next.verdict = VERDICT_AMEX;
            end else if (len_reg == LEN_W'(16) && top_reg == 4'd5 &&
                         sec_reg >= 4'd1 && sec_reg <= 4'd5) begin
                class_next.verdict = VERDICT_MASTERCARD;
            end else if ((len_reg == LEN_W'(16) || len_reg == LEN_W'(13)) &&
                         top_reg == 4'd4) begin
                class_next.verdict = VERDICT_VISA;
            end else begin
                class_next.verdict = VERDICT_INVALID;
            end
        end
    end

    // Scan sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SC_IDLE: begin
                    if (start) begin
                        sh_reg      <= bcd;
                        cnt_reg     <= '0;
                        sum_reg     <= '0;
                        mod_reg     <= '0;
                        len_reg     <= '0;
                        top_reg     <= '0;
                        sec_reg     <= '0;
                        prev_hi_reg <= '0;
                        state_reg   <= SC_RUN;
                    end
                end
                SC_RUN: begin
                    sh_reg      <= sh_reg >> (2 * DIGIT_W);
                    sum_reg     <= sum_reg + SUM_W'(lo_c) + SUM_W'(hi_c);
                    mod_reg     <= mod_next;
                    prev_hi_reg <= hi_dig;
                    cnt_reg     <= cnt_reg + 1'b1;
                    // track the highest nonzero digit and the one below it
                    if (hi_dig != '0) begin
                        len_reg <= LEN_W'(pos_lo + 2'd2);
                        top_reg <= hi_dig;
                        sec_reg <= lo_dig;
                    end else if (lo_dig != '0) begin
                        len_reg <= pos_hi;
                        top_reg <= lo_dig;
                        sec_reg <= prev_hi_reg;
                    end
                    if (cnt_reg == PAIR_CNT_W'(NUM_PAIRS - 1)) begin
                        state_reg <= SC_CLASS;
                    end
                end
                SC_CLASS: begin
                    result_reg <= class_next;
                    done_reg   <= 1'b1;
                    state_reg  <= SC_IDLE;
                end
                default: state_reg <= SC_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/luhn_card_classifier.sv -----
`timescale 1ns / 1ps
// An accepted input beat passes 16 conversion steps at four bits per cycle,
// 10 scan steps at two digits per cycle, a handoff and a classification step
// before m_tvalid. One card is in flight at a time, set by the single shared
// converter and scanner; the next card is taken once the result is in the
// output register, where it waits meanwhile. Reset (aresetn low, synchronous)
// empties the output and returns the block to idle.
// ----------------------------------------------------------------------------
// Luhn card classifier
// Checks the mod-ten checksum of a binary card number and reports its brand.
// ----------------------------------------------------------------------------
module luhn_card_classifier #(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcc_pkg::CARD_W-1:0]      s_tdata,   // [63:0] card_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcc_pkg::M_TDATA_W-1:0]   m_tdata    // [1:0] verdict, [2] luhn_ok,
                                                       // [10:3] digit_sum, [15:11] zero
);
    import lcc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SCAN, ST_HOLD} state_t;

    state_t             state_reg;
    logic               s_tready_reg;
    logic               m_tvalid_reg;
    logic               scan_start_reg;
    lcc_result_t        out_reg;

    logic               in_beat;
    logic               out_free;
    logic               conv_done;
    logic [BCD_W-1:0]   bcd;
    logic               scan_done;
    lcc_result_t        scan_result;

    assign in_beat  = s_tvalid && s_tready_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    lcc_bcd_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_beat),
        .card_value (s_tdata),
        .done       (conv_done),
        .bcd        (bcd)
    );

    lcc_luhn_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start_reg),
        .bcd     (bcd),
        .done    (scan_done),
        .result  (scan_result)
    );

    // Sequence one card through converter and scanner, hold the result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            s_tready_reg   <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            scan_start_reg <= 1'b0;
        end else begin
            scan_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        scan_start_reg <= 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        if (out_free) begin
                            out_reg      <= scan_result;
                            m_tvalid_reg <= 1'b1;
                            s_tready_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end else begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        out_reg      <= scan_result;
                        m_tvalid_reg <= 1'b1;
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.digit_sum, out_reg.luhn_ok, out_reg.verdict});

    // One card in flight: no new beat right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready_reg)
        else $error("input accepted while a card is in flight");

    // Converter finishes only while the sequencer waits for it
    a_conv_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion done outside conversion state");

    // Scanner finishes only while the sequencer waits for it
    a_scan_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("scan done outside scan state");

    // A brand is only reported for a passing checksum with a bounded sum
    a_verdict_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((out_reg.verdict == VERDICT_INVALID || out_reg.luhn_ok) &&
                          out_reg.digit_sum <= SUM_W'(SUM_MAX)))
        else $error("brand without checksum pass or digit sum out of range");

endmodule
